FILE: design/tem_pkg.sv
// shared types and constants of the tree ensemble predictor
`default_nettype none

package tem_pkg;

    // input word field widths
    localparam int OP_W      = 2;
    localparam int TSLOT_W   = 3;
    localparam int NSLOT_W   = 8;
    localparam int SPLIT_W   = 7;
    localparam int CHILD_W   = 8;
    localparam int NUM_W     = 32;
    localparam int FSLOT_W   = 6;
    localparam int TCOUNT_W  = 4;

    // sum of up to fifteen Q16.16 leaf values
    localparam int SUM_W     = NUM_W + TCOUNT_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_NODE = 2'd0;
    localparam logic [OP_W-1:0] OP_FEAT = 2'd1;
    localparam logic [OP_W-1:0] OP_EVAL = 2'd2;

    // one stored tree node
    typedef struct packed {
        logic signed [SPLIT_W-1:0] split;
        logic [CHILD_W-1:0]        left;
        logic [CHILD_W-1:0]        right;
        logic signed [NUM_W-1:0]   value;
    } node_t;

endpackage

`default_nettype wire

FILE: design/tem_in_if.sv
// input channel of the tree ensemble predictor
`default_nettype none

interface tem_in_if;
    import tem_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [TSLOT_W-1:0]        tree_slot;
    logic [NSLOT_W-1:0]        node_slot;
    logic signed [SPLIT_W-1:0] split_feature;
    logic [CHILD_W-1:0]        left_next;
    logic [CHILD_W-1:0]        right_next;
    logic signed [NUM_W-1:0]   node_number;
    logic [FSLOT_W-1:0]        feature_slot;
    logic signed [NUM_W-1:0]   feature_number;

    modport source
    (
        output valid, op, tree_slot, node_slot, split_feature, left_next, right_next,
        output node_number, feature_slot, feature_number,
        input  ready
    );

    modport sink
    (
        input  valid, op, tree_slot, node_slot, split_feature, left_next, right_next,
        input  node_number, feature_slot, feature_number,
        output ready
    );

endinterface

`default_nettype wire

FILE: design/tem_out_if.sv
// output channel of the tree ensemble predictor
`default_nettype none

interface tem_out_if;
    import tem_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [NUM_W-1:0] prediction;
    logic                    walk_fault;

    modport source
    (
        output valid, prediction, walk_fault,
        input  ready
    );

    modport sink
    (
        input  valid, prediction, walk_fault,
        output ready
    );

endinterface

`default_nettype wire

FILE: design/tree_ensemble_mean_predict.sv
// Regression tree ensemble predictor: loads node tables and a sample, walks
// each tree and returns the truncated mean of the leaf values.
// Channels: in_ch takes words with op = node write, feature write or evaluate;
// out_ch returns one word (prediction, walk_fault) for each evaluate.
// cfg_we/cfg_wdata set the tree count (0 acts as 1, above NUM_TREES clamps).
// Node and feature writes are stored as they are accepted. For each tree an evaluate
// reads a node, then for a split node its feature, compares and steps to a child;
// a leaf adds its value, and after the last tree a serial divider forms the mean.
// The node table is one ram read per step, so walking is strictly serial;
// in_ch.ready is low for the whole evaluation.
// A walk visiting NODES split nodes or pointing to a child >= NODES stops,
// adds 0 and sets walk_fault.
// The result sits in an output register; the block takes new words while it
// waits, and only stalls if a second result is ready before out_ch drains.
// Reset clears control state and sets the tree count to 1; tables are
// undefined until written.
`default_nettype none

module tree_ensemble_mean_predict
#(
    parameter int NUM_TREES = 8,
    parameter int NODES     = 256,
    parameter int FEATURES  = 64
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    tem_in_if.sink                          in_ch,
    tem_out_if.source                       out_ch,
    input  wire logic                       cfg_we,
    input  wire logic [tem_pkg::TCOUNT_W-1:0] cfg_wdata
);
    import tem_pkg::*;

    localparam int DEPTH   = NUM_TREES * NODES;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FEAT_AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int VIS_W   = $clog2(NODES);
    localparam int NODE_W  = $bits(node_t);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NODE  = 3'd1;
    localparam logic [2:0] S_SPLIT = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DIVGO = 3'd4;
    localparam logic [2:0] S_DIVW  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [TCOUNT_W-1:0] tcount_reg, tcount_next;
    logic [TCOUNT_W-1:0] count_reg, count_next;
    logic [TCOUNT_W-1:0] tree_reg, tree_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [CHILD_W-1:0]  cur_reg, cur_next;
    logic [VIS_W-1:0]    visits_reg, visits_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                fault_reg, fault_next;
    logic                feat_ok_reg, feat_ok_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [NUM_W-1:0] pred_reg, pred_next;
    logic                wfault_reg, wfault_next;

    logic                accept;
    logic                node_we, node_re;
    logic [ADDR_W-1:0]   node_waddr, node_raddr;
    node_t               node_wdata, node_q;
    logic [NODE_W-1:0]   node_rdata;
    logic                feat_we, feat_re;
    logic [FEAT_AW-1:0]  feat_waddr, feat_raddr;
    logic [NUM_W-1:0]    feat_rdata;
    logic signed [NUM_W-1:0] fv;
    logic [CHILD_W-1:0]  child;
    logic                tree_done;
    logic                div_start, div_done;
    logic signed [NUM_W-1:0] div_q;

    // storage
    tem_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_node_ram
    (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    tem_ram #(.WIDTH(NUM_W), .DEPTH(FEATURES)) u_feat_ram
    (
        .clk   (clk),
        .we    (feat_we),
        .waddr (feat_waddr),
        .wdata (in_ch.feature_number),
        .re    (feat_re),
        .raddr (feat_raddr),
        .rdata (feat_rdata)
    );

    tem_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign accept   = in_ch.valid && in_ch.ready;
    assign node_q   = node_t'(node_rdata);
    assign in_ch.ready = (state_reg == S_IDLE);

    // load writes
    always_comb
    begin
        node_we    = accept && (in_ch.op == OP_NODE)
                     && (int'(in_ch.tree_slot) < NUM_TREES)
                     && (int'(in_ch.node_slot) < NODES);
        node_waddr = ADDR_W'(ADDR_W'(in_ch.tree_slot) * ADDR_W'(NODES)
                     + ADDR_W'(in_ch.node_slot));
        node_wdata.split = in_ch.split_feature;
        node_wdata.left  = in_ch.left_next;
        node_wdata.right = in_ch.right_next;
        node_wdata.value = in_ch.node_number;
        feat_we    = accept && (in_ch.op == OP_FEAT)
                     && (int'(in_ch.feature_slot) < FEATURES);
        feat_waddr = FEAT_AW'(in_ch.feature_slot);
    end

    // walk sequencer
    always_comb
    begin
        state_next     = state_reg;
        tcount_next    = cfg_we ? cfg_wdata : tcount_reg;
        count_next     = count_reg;
        tree_next      = tree_reg;
        base_next      = base_reg;
        cur_next       = cur_reg;
        visits_next    = visits_reg;
        sum_next       = sum_reg;
        fault_next     = fault_reg;
        feat_ok_next   = feat_ok_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        pred_next      = pred_reg;
        wfault_next    = wfault_reg;
        node_re        = 1'b0;
        node_raddr     = ADDR_W'(base_reg + ADDR_W'(cur_reg));
        feat_re        = 1'b0;
        feat_raddr     = FEAT_AW'(node_q.split[FSLOT_W-1:0]);
        div_start      = 1'b0;
        tree_done      = 1'b0;
        fv             = feat_ok_reg ? signed'(feat_rdata) : '0;
        child          = (fv <= node_q.value) ? node_q.left : node_q.right;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_ch.op == OP_EVAL))
                begin
                    if (tcount_reg == '0)
                    begin
                        count_next = TCOUNT_W'(1);
                    end
                    else if (int'(tcount_reg) > NUM_TREES)
                    begin
                        count_next = TCOUNT_W'(NUM_TREES);
                    end
                    else
                    begin
                        count_next = tcount_reg;
                    end
                    tree_next   = '0;
                    base_next   = '0;
                    cur_next    = '0;
                    visits_next = '0;
                    sum_next    = '0;
                    fault_next  = 1'b0;
                    state_next  = S_NODE;
                end
            end
            S_NODE:
            begin
                node_re    = 1'b1;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (node_q.split[SPLIT_W-1])
                begin
                    sum_next  = sum_reg + SUM_W'(node_q.value);
                    tree_done = 1'b1;
                end
                else
                begin
                    feat_re      = 1'b1;
                    feat_ok_next = int'(node_q.split[FSLOT_W-1:0]) < FEATURES;
                    state_next   = S_CMP;
                end
            end
            S_CMP:
            begin
                if ((int'(child) >= NODES) || (visits_reg == VIS_W'(NODES - 1)))
                begin
                    fault_next = 1'b1;
                    tree_done  = 1'b1;
                end
                else
                begin
                    cur_next    = child;
                    visits_next = visits_reg + 1'b1;
                    state_next  = S_NODE;
                end
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    pred_next      = div_q;
                    wfault_next    = fault_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance to the next tree or to the divide
        if (tree_done)
        begin
            if (tree_reg + 1'b1 == count_reg)
            begin
                state_next = S_DIVGO;
            end
            else
            begin
                tree_next   = tree_reg + 1'b1;
                base_next   = ADDR_W'(base_reg + ADDR_W'(NODES));
                cur_next    = '0;
                visits_next = '0;
                state_next  = S_NODE;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tcount_reg    <= TCOUNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tcount_reg    <= tcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walk datapath and output word
    always_ff @(posedge clk)
    begin
        count_reg   <= count_next;
        tree_reg    <= tree_next;
        base_reg    <= base_next;
        cur_reg     <= cur_next;
        visits_reg  <= visits_next;
        sum_reg     <= sum_next;
        fault_reg   <= fault_next;
        feat_ok_reg <= feat_ok_next;
        pred_reg    <= pred_next;
        wfault_reg  <= wfault_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.prediction = pred_reg;
    assign out_ch.walk_fault = wfault_reg;

endmodule

`default_nettype wire

FILE: design/tem_ram.sv
// generic single write port ram with registered read
`default_nettype none

module tem_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/tem_div.sv
// bit-serial signed divider, one quotient bit per cycle
`default_nettype none

module tem_div
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [tem_pkg::SUM_W-1:0]   dividend,
    input  wire logic [tem_pkg::TCOUNT_W-1:0]       divisor,
    output logic                                done,
    output logic signed [tem_pkg::NUM_W-1:0]        quotient
);
    import tem_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   mag_reg, mag_next;
    logic [TCOUNT_W-1:0] rem_reg, rem_next;
    logic [TCOUNT_W-1:0] div_reg, div_next;
    logic               neg_reg, neg_next;
    logic [TCOUNT_W:0]  trial;
    logic [TCOUNT_W:0]  diff;

    // one restoring step on the magnitude
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, mag_reg[SUM_W-1]};
        diff      = trial - {1'b0, div_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W);
            mag_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            neg_next  = dividend[SUM_W-1];
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[TCOUNT_W-1:0];
                mag_next = {mag_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TCOUNT_W-1:0];
                mag_next = {mag_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    // truncated toward zero, sign restored
    assign done     = done_reg;
    assign quotient = neg_reg ? NUM_W'(-mag_reg[NUM_W-1:0]) : mag_reg[NUM_W-1:0];

endmodule

`default_nettype wire

FILE: design/tem_chk.sv
// port level checks of the tree ensemble predictor
`default_nettype none

module tem_chk
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic [tem_pkg::OP_W-1:0]    in_op,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [tem_pkg::NUM_W-1:0]   prediction,
    input wire logic                        walk_fault
);
    import tem_pkg::*;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(prediction) && $stable(walk_fault))
        else $error("result payload changed while stalled");

    // an evaluate occupies the block
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_op == OP_EVAL) |=> !in_ready)
        else $error("ready after evaluate word");

    // a new result only comes out of an evaluation
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result word without evaluation");

endmodule

bind tree_ensemble_mean_predict tem_chk u_tem_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_op      (in_ch.op),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .prediction (out_ch.prediction),
    .walk_fault (out_ch.walk_fault)
);

`default_nettype wire

FILE: tb/tree_ensemble_mean_predict_tb.sv
// testbench of the tree ensemble predictor: directed and random words, predicted means checked
`default_nettype none

module tree_ensemble_mean_predict_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tem_pkg::*;

    localparam int TREE_SLOTS     = 8;
    localparam int NODE_COUNT     = 256;
    localparam int FEATURE_COUNT  = 64;
    localparam int RANDOM_WORDS   = 1720;
    localparam int CFG_PERIOD     = 250;
    localparam int SETTLE_CYCLES  = 10;
    localparam int TAIL_CYCLES    = 50;
    localparam int WATCHDOG_LIMIT = 40000;

    // op code the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic signed [NUM_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [NUM_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic [TSLOT_W-1:0]        tree_slot;
        logic [NSLOT_W-1:0]        node_slot;
        logic signed [SPLIT_W-1:0] split_feature;
        logic [CHILD_W-1:0]        left_next;
        logic [CHILD_W-1:0]        right_next;
        logic signed [NUM_W-1:0]   node_number;
        logic [FSLOT_W-1:0]        feature_slot;
        logic signed [NUM_W-1:0]   feature_number;
    } in_word_t;

    typedef struct {
        logic signed [NUM_W-1:0] prediction;
        logic                    walk_fault;
    } mean_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [TCOUNT_W-1:0] cfg_wdata;

    tem_in_if  in_ch();
    tem_out_if out_ch();

    tree_ensemble_mean_predict
    #(
        .NUM_TREES (TREE_SLOTS),
        .NODES     (NODE_COUNT),
        .FEATURES  (FEATURE_COUNT)
    )
    DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the node tables, sample and tree count
    node_t               node_mem   [TREE_SLOTS][NODE_COUNT];
    bit                  node_known [TREE_SLOTS][NODE_COUNT];
    logic signed [NUM_W-1:0] feat_mem   [FEATURE_COUNT];
    bit                  feat_known [FEATURE_COUNT];
    logic [TCOUNT_W-1:0] trees_cfg = 4'd1;

    mean_t expected_means[$];

    bit no_idle = 1'b0;
    int mismatches = 0;
    int words_loaded = 0;
    int evals_checked = 0;
    int faults_seen = 0;
    int counts_set = 0;
    int quiet_cycles = 0;

    // walk one tree from node 0; flags the first entry read that was never written
    function automatic logic signed [NUM_W-1:0] descend_tree(input int tree, output bit fault,
                                                             output int miss_node,
                                                             output int miss_feat);
        int                      cur;
        int                      fidx;
        node_t                   nd;
        logic signed [NUM_W-1:0] fv;
        logic [CHILD_W-1:0]      next_node;
        cur = 0;
        fault = 1'b0;
        miss_node = -1;
        miss_feat = -1;
        for (int visits = 0; visits < NODE_COUNT; visits++)
        begin
            if (!node_known[tree][cur])
            begin
                miss_node = cur;
                return '0;
            end
            nd = node_mem[tree][cur];
            // any negative split index is a leaf
            if ($signed(nd.split) < 0)
                return nd.value;
            fidx = int'($signed(nd.split));
            fv = '0;
            if (fidx < FEATURE_COUNT)
            begin
                if (!feat_known[fidx])
                begin
                    miss_feat = fidx;
                    return '0;
                end
                fv = feat_mem[fidx];
            end
            next_node = ($signed(fv) <= $signed(nd.value)) ? nd.left : nd.right;
            if (int'(next_node) >= NODE_COUNT)
                break;
            cur = int'(next_node);
        end
        fault = 1'b1;
        return '0;
    endfunction

    // mean of the leaf values over the trees in use; 0 if an unwritten entry is in the way
    function automatic bit ensemble_mean(output mean_t m, output int miss_tree,
                                         output int miss_node, output int miss_feat);
        int                      cnt;
        longint                  sum;
        longint                  quo;
        bit                      tree_fault;
        logic signed [NUM_W-1:0] leaf;
        cnt = (trees_cfg == 0) ? 1 : ((trees_cfg > TREE_SLOTS) ? TREE_SLOTS : int'(trees_cfg));
        sum = 0;
        m.walk_fault = 1'b0;
        miss_tree = -1;
        for (int t = 0; t < cnt; t++)
        begin
            leaf = descend_tree(t, tree_fault, miss_node, miss_feat);
            if (miss_node >= 0 || miss_feat >= 0)
            begin
                miss_tree = t;
                return 1'b0;
            end
            sum += leaf;
            if (tree_fault)
                m.walk_fault = 1'b1;
        end
        // truncation toward zero
        quo = sum / longint'(cnt);
        m.prediction = quo[NUM_W-1:0];
        return 1'b1;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w.op             = OP_W'($urandom_range(0, 3));
        w.tree_slot      = TSLOT_W'($urandom());
        w.node_slot      = NSLOT_W'($urandom());
        w.split_feature  = SPLIT_W'($urandom());
        w.left_next      = CHILD_W'($urandom());
        w.right_next     = CHILD_W'($urandom());
        w.node_number    = $urandom();
        w.feature_slot   = FSLOT_W'($urandom());
        w.feature_number = $urandom();
        return w;
    endfunction

    function automatic in_word_t node_word(input int tree, input int node,
                                           input logic signed [SPLIT_W-1:0] split,
                                           input int left, input int right,
                                           input logic signed [NUM_W-1:0] number);
        in_word_t w;
        w = random_word();
        w.op            = OP_NODE;
        w.tree_slot     = TSLOT_W'(tree);
        w.node_slot     = NSLOT_W'(node);
        w.split_feature = split;
        w.left_next     = CHILD_W'(left);
        w.right_next    = CHILD_W'(right);
        w.node_number   = number;
        return w;
    endfunction

    function automatic in_word_t feat_word(input int slot, input logic signed [NUM_W-1:0] number);
        in_word_t w;
        w = random_word();
        w.op             = OP_FEAT;
        w.feature_slot   = FSLOT_W'(slot);
        w.feature_number = number;
        return w;
    endfunction

    // random node: many leaves, some short back links so that loops show up
    function automatic in_word_t with_node_content(in_word_t w);
        int fidx;
        if ($urandom_range(0, 99) < 45)
            w.split_feature = SPLIT_W'($urandom_range(64, 127));
        else
            w.split_feature = SPLIT_W'($urandom_range(0, FEATURE_COUNT - 1));
        w.left_next  = ($urandom_range(0, 9) == 0) ? CHILD_W'($urandom_range(0, 7))
                                                   : CHILD_W'($urandom());
        w.right_next = ($urandom_range(0, 9) == 0) ? CHILD_W'($urandom_range(0, 7))
                                                   : CHILD_W'($urandom());
        fidx = int'($signed(w.split_feature));
        case ($urandom_range(0, 9))
            0: w.node_number = Q_MAX;
            1: w.node_number = Q_MIN;
            // threshold equal to the feature it compares
            2, 3: w.node_number = (fidx >= 0 && feat_known[fidx]) ? feat_mem[fidx] : $urandom();
            default: w.node_number = $urandom();
        endcase
        return w;
    endfunction

    function automatic in_word_t with_feature_content(in_word_t w);
        int t;
        int n;
        t = $urandom_range(0, TREE_SLOTS - 1);
        n = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0: w.feature_number = Q_MAX;
            1: w.feature_number = Q_MIN;
            2: w.feature_number = node_known[t][n] ? node_mem[t][n].value : $urandom();
            default: w.feature_number = $urandom();
        endcase
        return w;
    endfunction

    // drive one word, wait for the handshake, update the shadow state
    task automatic send_word(input in_word_t w);
        int    gap;
        mean_t m;
        int    mt;
        int    mn;
        int    mf;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.op             <= w.op;
        in_ch.tree_slot      <= w.tree_slot;
        in_ch.node_slot      <= w.node_slot;
        in_ch.split_feature  <= w.split_feature;
        in_ch.left_next      <= w.left_next;
        in_ch.right_next     <= w.right_next;
        in_ch.node_number    <= w.node_number;
        in_ch.feature_slot   <= w.feature_slot;
        in_ch.feature_number <= w.feature_number;
        do
            @(posedge clk);
        while (!in_ch.ready);
        case (w.op)
            OP_NODE:
            begin
                node_mem[w.tree_slot][w.node_slot] =
                    '{w.split_feature, w.left_next, w.right_next, w.node_number};
                node_known[w.tree_slot][w.node_slot] = 1'b1;
                words_loaded++;
            end
            OP_FEAT:
            begin
                feat_mem[w.feature_slot] = w.feature_number;
                feat_known[w.feature_slot] = 1'b1;
                words_loaded++;
            end
            OP_EVAL:
            begin
                void'(ensemble_mean(m, mt, mn, mf));
                expected_means.push_back(m);
                words_loaded++;
            end
            default:
            begin
            end
        endcase
    endtask

    // fill whatever the walks would read unwritten, then evaluate
    task automatic evaluate_sample();
        mean_t    m;
        int       mt;
        int       mn;
        int       mf;
        in_word_t w;
        while (!ensemble_mean(m, mt, mn, mf))
        begin
            w = random_word();
            if (mn >= 0)
            begin
                w.op = OP_NODE;
                w.tree_slot = TSLOT_W'(mt);
                w.node_slot = NSLOT_W'(mn);
                w = with_node_content(w);
            end
            else
            begin
                w.op = OP_FEAT;
                w.feature_slot = FSLOT_W'(mf);
                w = with_feature_content(w);
            end
            send_word(w);
        end
        w = random_word();
        w.op = OP_EVAL;
        send_word(w);
    endtask

    // let every result drain and the block go idle
    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_tree_count(input logic [TCOUNT_W-1:0] cnt);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cnt;
        @(posedge clk);
        cfg_we    <= 1'b0;
        trees_cfg = cnt;
        counts_set++;
    endtask

    // signed compare at both ends of the range, equality included
    task automatic test_split_compare();
        send_word(feat_word(0, Q_MAX));
        send_word(feat_word(63, Q_MIN));
        send_word(node_word(0, 0, 7'sd0, 255, 1, Q_MAX));
        send_word(node_word(0, 255, -7'sd1, 0, 0, Q_MAX));
        send_word(node_word(0, 1, -7'sd64, 0, 0, Q_MIN));
        evaluate_sample();
        send_word(node_word(0, 0, 7'sd63, 255, 1, Q_MIN));
        evaluate_sample();
        send_word(node_word(0, 0, 7'sd0, 255, 1, Q_MAX - 1));
        evaluate_sample();
    endtask

    // full ensemble, clamped counts and truncation of a negative mean
    task automatic test_tree_count();
        for (int t = 1; t < TREE_SLOTS; t++)
            send_word(node_word(t, 0, SPLIT_W'(-9 * t), 0, 0, -32'sd1));
        set_tree_count(4'd8);
        evaluate_sample();
        set_tree_count(4'd15);
        evaluate_sample();
        set_tree_count(4'd0);
        evaluate_sample();
        set_tree_count(4'd3);
        evaluate_sample();
    endtask

    // tree 0 loops on itself, the walk must give up
    task automatic test_walk_fault();
        send_word(node_word(0, 0, 7'sd0, 0, 0, 32'sd0));
        evaluate_sample();
        set_tree_count(4'd1);
        evaluate_sample();
    endtask

    // spare op gives no word and leaves the tables alone
    task automatic test_unused_op();
        in_word_t w;
        repeat (2)
        begin
            w = random_word();
            w.op = OP_SPARE;
            send_word(w);
        end
        evaluate_sample();
    endtask

    task automatic test_random_ensemble();
        int                  next_cfg;
        int                  pick;
        logic [TCOUNT_W-1:0] cnt;
        in_word_t            w;
        next_cfg = words_loaded;
        while (words_loaded < RANDOM_WORDS + next_cfg - next_cfg % 1 && words_loaded < 1750)
        begin
            // new tree count every so often, extremes favored
            if (words_loaded >= next_cfg)
            begin
                case ($urandom_range(0, 7))
                    0: cnt = 4'd0;
                    1: cnt = 4'd15;
                    2: cnt = 4'd8;
                    3: cnt = 4'd1;
                    default: cnt = TCOUNT_W'($urandom_range(0, 15));
                endcase
                set_tree_count(cnt);
                next_cfg += CFG_PERIOD;
            end
            if ($urandom_range(0, 49) == 0)
                no_idle = !no_idle;
            pick = $urandom_range(0, 99);
            w = random_word();
            if (pick < 30)
            begin
                w.op = OP_NODE;
                send_word(with_node_content(w));
            end
            else if (pick < 50)
            begin
                w.op = OP_FEAT;
                send_word(with_feature_content(w));
            end
            else if (pick < 55)
            begin
                w.op = OP_SPARE;
                send_word(w);
            end
            else
                evaluate_sample();
        end
        no_idle = 1'b0;
    endtask

    // stimulus
    initial
    begin : stimulus
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.op             <= OP_NODE;
        in_ch.tree_slot      <= '0;
        in_ch.node_slot      <= '0;
        in_ch.split_feature  <= '0;
        in_ch.left_next      <= '0;
        in_ch.right_next     <= '0;
        in_ch.node_number    <= '0;
        in_ch.feature_slot   <= '0;
        in_ch.feature_number <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_split_compare();
        test_tree_count();
        test_walk_fault();
        test_unused_op();
        test_random_ensemble();

        settle_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_means.size() != 0)
        begin
            $error("%0d predictions never arrived", expected_means.size());
            mismatches++;
        end
        $display("%0d words loaded, %0d predictions checked, %0d of them with a walk fault",
                 words_loaded, evals_checked, faults_seen);
        $display("%0d tree count settings applied, from 0 up to 15", counts_set);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result side: random back-pressure, each word checked against the oldest prediction
    initial
    begin : result_check
        int    hold;
        mean_t want;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 7);
            if (hold != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            if (expected_means.size() == 0)
            begin
                $error("unexpected word: prediction %0d walk_fault %0b",
                       out_ch.prediction, out_ch.walk_fault);
                mismatches++;
            end
            else
            begin
                want = expected_means.pop_front();
                evals_checked++;
                if (want.walk_fault)
                    faults_seen++;
                if (out_ch.prediction !== want.prediction)
                begin
                    $error("prediction: expected %0d, got %0d", want.prediction, out_ch.prediction);
                    mismatches++;
                end
                if (out_ch.walk_fault !== want.walk_fault)
                begin
                    $error("walk_fault: expected %0b, got %0b", want.walk_fault, out_ch.walk_fault);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

`default_nettype wire
